### src/sip_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sip_pkg
// Shared types and constants for the saturating integer power block.
// ----------------------------------------------------------------------------
package sip_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned ExpW  = 31;
  localparam int unsigned HalfW = DataW / 2;
  localparam int unsigned ProdW = 2 * DataW;

  // Largest positive 64-bit two's complement value.
  localparam logic [DataW-1:0] SatLimit = {1'b0, {(DataW-1){1'b1}}};

  // Request to the shared multiplier.
  typedef struct packed {
    logic             start;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
  } mul_req_t;

  // Response from the shared multiplier.
  typedef struct packed {
    logic             done;
    logic [DataW-1:0] prod;  // low half of the full product
    logic             ovf;   // full product above SatLimit
  } mul_rsp_t;

endpackage
`default_nettype wire

### src/sip_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sip_mul
// 64x64 unsigned multiplier built from one 32x32 multiplier, four partial
// products per transaction, with an overflow check against SatLimit.
// ----------------------------------------------------------------------------
module sip_mul (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sip_pkg::mul_req_t req_i,
  output sip_pkg::mul_rsp_t      rsp_o
);

  logic [sip_pkg::DataW-1:0] a_q, b_q;
  logic [1:0]                cnt_q;
  logic                      issue_q;
  logic                      pp_v_q;
  logic                      pp_last_q;
  logic [sip_pkg::DataW-1:0] pp_q;
  logic [1:0]                sh_q;
  logic [sip_pkg::ProdW-1:0] sum_q;
  logic                      done_q;

  logic [sip_pkg::HalfW-1:0] a_part, b_part;
  logic [sip_pkg::ProdW-1:0] pp_shifted;

  assign a_part = cnt_q[1] ? a_q[sip_pkg::DataW-1:sip_pkg::HalfW] : a_q[sip_pkg::HalfW-1:0];
  assign b_part = cnt_q[0] ? b_q[sip_pkg::DataW-1:sip_pkg::HalfW] : b_q[sip_pkg::HalfW-1:0];

  always_comb begin
    case (sh_q)
      2'd0:    pp_shifted = {{sip_pkg::DataW{1'b0}}, pp_q};
      2'd1:    pp_shifted = {{sip_pkg::HalfW{1'b0}}, pp_q, {sip_pkg::HalfW{1'b0}}};
      2'd2:    pp_shifted = {pp_q, {sip_pkg::DataW{1'b0}}};
      default: pp_shifted = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q   <= 1'b0;
      pp_v_q    <= 1'b0;
      pp_last_q <= 1'b0;
      done_q    <= 1'b0;
      cnt_q     <= '0;
    end else begin
      // stage 1: one 32x32 partial product per cycle
      if (req_i.start) begin
        a_q     <= req_i.a;
        b_q     <= req_i.b;
        cnt_q   <= '0;
        issue_q <= 1'b1;
        pp_v_q  <= 1'b0;
        sum_q   <= '0;
        done_q  <= 1'b0;
      end else begin
        pp_v_q <= issue_q;
        done_q <= pp_v_q & pp_last_q;
        if (issue_q) begin
          pp_q      <= {{sip_pkg::HalfW{1'b0}}, a_part} * {{sip_pkg::HalfW{1'b0}}, b_part};
          sh_q      <= {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};
          pp_last_q <= (cnt_q == 2'd3);
          cnt_q     <= cnt_q + 2'd1;
          if (cnt_q == 2'd3) begin
            issue_q <= 1'b0;
          end
        end
        // stage 2: accumulate
        if (pp_v_q) begin
          sum_q <= sum_q + pp_shifted;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = sum_q[sip_pkg::DataW-1:0];
  assign rsp_o.ovf  = |sum_q[sip_pkg::ProdW-1:sip_pkg::DataW-1];

endmodule
`default_nettype wire

### src/saturating_integer_power.sv
`default_nettype none
// ----------------------------------------------------------------------------
// saturating_integer_power
// Signed 64-bit base raised to a 31-bit exponent by square-and-multiply,
// saturating to the largest positive value with an overflow flag.
// ----------------------------------------------------------------------------
// A zero base or zero exponent goes straight to the output stage. Each
// 64-bit product holds the sequencer on the shared 32x32 multiplier
// through operand load, four partial products and final accumulate;
// every bit needs up to two products.
// One transaction at a time; a new one is taken while a result still waits.
// Reset (rst_ni low, asynchronous) idles the sequencer and drops out_valid_o.
// ----------------------------------------------------------------------------
module saturating_integer_power (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [sip_pkg::DataW-1:0] base_value_i,
  input  wire logic [sip_pkg::ExpW-1:0]  exponent_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [sip_pkg::DataW-1:0]      power_o,
  output logic                           overflowed_o
);

  typedef enum logic [2:0] {
    StIdle,
    StStep,     // look at the current exponent bit
    StWaitAcc,  // acc * mag in flight
    StShift,    // drop the bit, square if more bits remain
    StWaitSq,   // mag * mag in flight
    StFinish    // hand result to the output register
  } state_e;

  state_e                    state_q;
  logic [sip_pkg::DataW-1:0] acc_q, mag_q;
  logic [sip_pkg::ExpW-1:0]  exp_q;
  logic                      neg_q;
  logic [sip_pkg::DataW-1:0] res_q;
  logic                      res_ovf_q;
  logic                      out_valid_q;
  logic [sip_pkg::DataW-1:0] power_q;
  logic                      ovf_q;

  sip_pkg::mul_req_t mul_req;
  sip_pkg::mul_rsp_t mul_rsp;

  logic in_fire;
  logic out_load;
  logic [sip_pkg::ExpW-1:0] exp_next;

  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i && in_ready_o;
  assign exp_next   = exp_q >> 1;
  // result moves into the output register once that register is free
  assign out_load   = (state_q == StFinish) && (!out_valid_q || out_ready_i);

  // Multiplier is started from the step states; operands are latched there.
  always_comb begin
    mul_req.start = 1'b0;
    mul_req.a     = acc_q;
    mul_req.b     = mag_q;
    case (state_q)
      StStep: begin
        mul_req.start = exp_q[0];
      end
      StShift: begin
        mul_req.start = (exp_next != '0);
        mul_req.a     = mag_q;
      end
      default: begin
        mul_req.start = 1'b0;
      end
    endcase
  end

  sip_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_fire) begin
            acc_q     <= {{(sip_pkg::DataW-1){1'b0}}, 1'b1};
            // two's complement magnitude; the most negative base gives 2^63
            mag_q     <= base_value_i[sip_pkg::DataW-1] ? ('0 - base_value_i)
                                                        : base_value_i;
            neg_q     <= base_value_i[sip_pkg::DataW-1] & exponent_i[0];
            exp_q     <= exponent_i;
            res_ovf_q <= 1'b0;
            if (base_value_i == '0) begin
              // zero base: 1 only for a zero exponent
              res_q   <= {{(sip_pkg::DataW-1){1'b0}}, (exponent_i == '0)};
              state_q <= StFinish;
            end else if (exponent_i == '0) begin
              res_q   <= {{(sip_pkg::DataW-1){1'b0}}, 1'b1};
              state_q <= StFinish;
            end else begin
              state_q <= StStep;
            end
          end
        end
        StStep: begin
          state_q <= exp_q[0] ? StWaitAcc : StShift;
        end
        StWaitAcc: begin
          if (mul_rsp.done) begin
            if (mul_rsp.ovf) begin
              res_q     <= sip_pkg::SatLimit;
              res_ovf_q <= 1'b1;
              state_q   <= StFinish;
            end else begin
              acc_q   <= mul_rsp.prod;
              state_q <= StShift;
            end
          end
        end
        StShift: begin
          exp_q <= exp_next;
          if (exp_next == '0) begin
            res_q   <= neg_q ? ('0 - acc_q) : acc_q;
            state_q <= StFinish;
          end else begin
            state_q <= StWaitSq;
          end
        end
        StWaitSq: begin
          if (mul_rsp.done) begin
            if (mul_rsp.ovf) begin
              res_q     <= sip_pkg::SatLimit;
              res_ovf_q <= 1'b1;
              state_q   <= StFinish;
            end else begin
              mag_q   <= mul_rsp.prod;
              state_q <= StStep;
            end
          end
        end
        StFinish: begin
          // wait for the output register to free up
          if (out_load) begin
            power_q <= res_q;
            ovf_q   <= res_ovf_q;
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign power_o      = power_q;
  assign overflowed_o = ovf_q;

endmodule
`default_nettype wire
